// ===== hdl/slipc_pkg.sv =====
// Shared types and constants for the SLIP codec behind the SPI slave.
// Holds the register indexes, their reset values and the transmit FIFO entry type.
// No dependencies.
`timescale 1ns / 1ps

package slipc_pkg;

  localparam int BYTE_W = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_CODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_END_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESC_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CODE    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] END_CODE_RST     = 8'd192;
  localparam logic [BYTE_W-1:0] ESC_CODE_RST     = 8'd219;
  localparam logic [BYTE_W-1:0] ESC_END_CODE_RST = 8'd220;
  localparam logic [BYTE_W-1:0] ESC_ESC_CODE_RST = 8'd221;
  localparam logic [BYTE_W-1:0] IDLE_CODE_RST    = 8'd0;

  // One transmit FIFO entry: the raw byte and the end-of-message mark.
  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } fifo_entry_t;

endpackage

// ===== hdl/slip_spi_slave_codec_unit.sv =====
// SLIP codec behind an SPI slave: top level with receive decoder and transmit encoder.
// Each result is loaded into the output register on the transfer of its item.
// Throughput: one item per cycle while out_ready is high; the FIFO head register is refilled every cycle.
// Reset (synchronous, active low) clears codec state, FIFO pointers and configuration;
// FIFO storage is not cleared and needs no clearing pass.
// Depends on slipc_pkg and slipc_tx_fifo.
`timescale 1ns / 1ps

module slip_spi_slave_codec_unit #(
  parameter int TX_FIFO_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [slipc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slipc_pkg::BYTE_W-1:0]    cfg_wdata,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [slipc_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic [slipc_pkg::BYTE_W-1:0]    in_tx_byte,
  input  logic                            in_tx_last,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [slipc_pkg::BYTE_W-1:0]    out_next_tx_byte,
  output logic                            out_rx_data_valid,
  output logic [slipc_pkg::BYTE_W-1:0]    out_rx_data,
  output logic                            out_rx_frame_end,
  output logic                            out_rx_frame_abort,
  output logic                            out_push_accepted
);
  import slipc_pkg::*;

  localparam int CNT_W = $clog2(TX_FIFO_DEPTH + 1);

  // Configuration registers
  logic [BYTE_W-1:0] end_code_r, esc_code_r, esc_end_code_r, esc_esc_code_r, idle_code_r;

  // Codec state
  logic              rx_in_frame_r, rx_in_frame_nxt;
  logic              rx_escape_armed_r, rx_escape_armed_nxt;
  logic              tx_in_message_r, tx_in_message_nxt;
  logic              tx_escape_pending_r, tx_escape_pending_nxt;
  logic              tx_end_due_r, tx_end_due_nxt;
  logic [BYTE_W-1:0] tx_pending_code_r, tx_pending_code_nxt;
  logic [CNT_W-1:0]  msg_count_r, msg_count_nxt;

  // Result register
  logic              out_valid_r;
  logic [BYTE_W-1:0] next_tx_byte_r, next_tx_byte_nxt;
  logic              rx_data_valid_r, rx_data_valid_nxt;
  logic [BYTE_W-1:0] rx_data_r, rx_data_nxt;
  logic              rx_frame_end_r, rx_frame_end_nxt;
  logic              rx_frame_abort_r, rx_frame_abort_nxt;
  logic              push_accepted_r, push_accepted_nxt;

  // FIFO interface
  logic              fifo_push, fifo_pop, fifo_full;
  fifo_entry_t       fifo_push_entry, fifo_head;
  logic [CNT_W-1:0]  fifo_count;

  logic              accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign fifo_push_entry.last = in_tx_last;
  assign fifo_push_entry.data = in_tx_byte;

  slipc_tx_fifo #(
    .DEPTH (TX_FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_tx_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fifo_push),
    .push_entry (fifo_push_entry),
    .pop        (fifo_pop),
    .head       (fifo_head),
    .count      (fifo_count),
    .full       (fifo_full)
  );

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_code_r     <= END_CODE_RST;
      esc_code_r     <= ESC_CODE_RST;
      esc_end_code_r <= ESC_END_CODE_RST;
      esc_esc_code_r <= ESC_ESC_CODE_RST;
      idle_code_r    <= IDLE_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_END_CODE:     end_code_r     <= cfg_wdata;
        CFG_ESC_CODE:     esc_code_r     <= cfg_wdata;
        CFG_ESC_END_CODE: esc_end_code_r <= cfg_wdata;
        CFG_ESC_ESC_CODE: esc_esc_code_r <= cfg_wdata;
        CFG_IDLE_CODE:    idle_code_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-item work: FIFO push, or receive decode plus transmit encode for an exchange.
  always_comb begin
    rx_in_frame_nxt       = rx_in_frame_r;
    rx_escape_armed_nxt   = rx_escape_armed_r;
    tx_in_message_nxt     = tx_in_message_r;
    tx_escape_pending_nxt = tx_escape_pending_r;
    tx_end_due_nxt        = tx_end_due_r;
    tx_pending_code_nxt   = tx_pending_code_r;
    msg_count_nxt         = msg_count_r;
    next_tx_byte_nxt      = '0;
    rx_data_valid_nxt     = 1'b0;
    rx_data_nxt           = '0;
    rx_frame_end_nxt      = 1'b0;
    rx_frame_abort_nxt    = 1'b0;
    push_accepted_nxt     = 1'b0;
    fifo_push             = 1'b0;
    fifo_pop              = 1'b0;

    if (accept) begin
      if (in_func) begin
        // Push a message byte unless the FIFO is full.
        if (!fifo_full) begin
          fifo_push         = 1'b1;
          push_accepted_nxt = 1'b1;
          if (in_tx_last) begin
            msg_count_nxt = msg_count_r + 1'b1;
          end
        end
      end else begin
        // Receive decoder. The end code is tested before everything else in a frame.
        if (!rx_in_frame_r) begin
          if (in_rx_byte != idle_code_r) begin
            rx_in_frame_nxt     = 1'b1;
            rx_escape_armed_nxt = 1'b0;
            rx_data_valid_nxt   = 1'b1;
            rx_data_nxt         = in_rx_byte;
          end
        end else if (in_rx_byte == end_code_r) begin
          rx_in_frame_nxt     = 1'b0;
          rx_escape_armed_nxt = 1'b0;
          rx_frame_end_nxt    = 1'b1;
        end else if (rx_escape_armed_r) begin
          rx_escape_armed_nxt = 1'b0;
          if (in_rx_byte == esc_esc_code_r) begin
            rx_data_valid_nxt = 1'b1;
            rx_data_nxt       = esc_code_r;
          end else if (in_rx_byte == esc_end_code_r) begin
            rx_data_valid_nxt = 1'b1;
            rx_data_nxt       = end_code_r;
          end else begin
            rx_in_frame_nxt    = 1'b0;
            rx_frame_abort_nxt = 1'b1;
          end
        end else if (in_rx_byte == esc_code_r) begin
          rx_escape_armed_nxt = 1'b1;
        end else begin
          rx_data_valid_nxt = 1'b1;
          rx_data_nxt       = in_rx_byte;
        end

        // Transmit encoder. A message starts only once a complete one is queued.
        if (!tx_in_message_r && (msg_count_r == '0 || fifo_count == '0)) begin
          next_tx_byte_nxt = idle_code_r;
        end else if (tx_in_message_r && tx_escape_pending_r) begin
          tx_escape_pending_nxt = 1'b0;
          next_tx_byte_nxt      = tx_pending_code_r;
        end else if ((tx_in_message_r && tx_end_due_r) || fifo_count == '0) begin
          tx_end_due_nxt        = 1'b0;
          tx_in_message_nxt     = 1'b0;
          tx_escape_pending_nxt = 1'b0;
          next_tx_byte_nxt      = end_code_r;
        end else begin
          fifo_pop              = 1'b1;
          tx_in_message_nxt     = 1'b1;
          tx_escape_pending_nxt = 1'b0;
          tx_end_due_nxt        = 1'b0;
          if (fifo_head.data == end_code_r) begin
            next_tx_byte_nxt      = esc_code_r;
            tx_pending_code_nxt   = esc_end_code_r;
            tx_escape_pending_nxt = 1'b1;
          end else if (fifo_head.data == esc_code_r) begin
            next_tx_byte_nxt      = esc_code_r;
            tx_pending_code_nxt   = esc_esc_code_r;
            tx_escape_pending_nxt = 1'b1;
          end else begin
            next_tx_byte_nxt = fifo_head.data;
          end
          if (fifo_head.last) begin
            tx_end_due_nxt = 1'b1;
            if (msg_count_r != '0) begin
              msg_count_nxt = msg_count_r - 1'b1;
            end
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_in_frame_r       <= 1'b0;
      rx_escape_armed_r   <= 1'b0;
      tx_in_message_r     <= 1'b0;
      tx_escape_pending_r <= 1'b0;
      tx_end_due_r        <= 1'b0;
      tx_pending_code_r   <= '0;
      msg_count_r         <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      rx_in_frame_r       <= rx_in_frame_nxt;
      rx_escape_armed_r   <= rx_escape_armed_nxt;
      tx_in_message_r     <= tx_in_message_nxt;
      tx_escape_pending_r <= tx_escape_pending_nxt;
      tx_end_due_r        <= tx_end_due_nxt;
      tx_pending_code_r   <= tx_pending_code_nxt;
      msg_count_r         <= msg_count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      next_tx_byte_r   <= next_tx_byte_nxt;
      rx_data_valid_r  <= rx_data_valid_nxt;
      rx_data_r        <= rx_data_nxt;
      rx_frame_end_r   <= rx_frame_end_nxt;
      rx_frame_abort_r <= rx_frame_abort_nxt;
      push_accepted_r  <= push_accepted_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_tx_byte   = next_tx_byte_r;
  assign out_rx_data_valid  = rx_data_valid_r;
  assign out_rx_data        = rx_data_r;
  assign out_rx_frame_end   = rx_frame_end_r;
  assign out_rx_frame_abort = rx_frame_abort_r;
  assign out_push_accepted  = push_accepted_r;

`ifndef SYNTHESIS
  // The FIFO never holds more entries than it has slots.
  a_fifo_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= CNT_W'(TX_FIFO_DEPTH))
    else $error("transmit FIFO count exceeds its depth");

  // Every complete message counted has its last byte still in the FIFO.
  a_msg_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    msg_count_r <= fifo_count)
    else $error("complete message count exceeds FIFO count");

  // An escape is armed only inside a received frame.
  a_rx_escape_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    rx_escape_armed_r |-> rx_in_frame_r)
    else $error("receive escape armed outside a frame");

  // A pending escape code is sent only inside a transmitted message.
  a_tx_escape_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    tx_escape_pending_r |-> tx_in_message_r)
    else $error("transmit escape pending outside a message");

  // A push transfer never produces receive results or a transmit byte.
  a_push_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func) |=> (!out_rx_data_valid && !out_rx_frame_end &&
                            !out_rx_frame_abort && out_next_tx_byte == '0))
    else $error("push transfer produced exchange results");
`endif

endmodule

// ===== hdl/slipc_tx_fifo.sv =====
// Transmit message FIFO of the SLIP codec: a memory with a registered head entry.
// Depends on slipc_pkg for the entry type.
`timescale 1ns / 1ps

module slipc_tx_fifo #(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  slipc_pkg::fifo_entry_t push_entry,
  input  logic                 pop,
  output slipc_pkg::fifo_entry_t head,
  output logic [CNT_W-1:0]     count,
  output logic                 full
);
  import slipc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  fifo_entry_t       mem [DEPTH];
  fifo_entry_t       head_r;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              bypass;

  // Pointer and count updates; push and pop never fall in the same cycle.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end else if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  // A write to the slot about to become the head goes straight to the head register.
  assign bypass = push && (wr_ptr_r == rd_ptr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
    if (bypass) begin
      head_r <= push_entry;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign head  = head_r;
  assign count = count_r;
  assign full  = (count_r == CNT_W'(DEPTH));

endmodule
